// ----- rtl/hwmac_pkg.sv -----
// Shared types and constants of the hashed-weight int8 MAC tile.
// Used by hwmac_front, hwmac_back and the top level; depends on nothing.
package hwmac_pkg;

    localparam int TILE_LANES  = 8;
    localparam int OUT_LANES   = 8;
    localparam int LANE_W      = (TILE_LANES > 1) ? $clog2(TILE_LANES) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] KEY_GOLDEN = 32'h9e3779b9;
    localparam logic [31:0] KEY_LAYER  = 32'h85ebca6b;
    localparam logic [31:0] KEY_TENSOR = 32'hc2b2ae35;
    localparam logic [31:0] KEY_INDEX  = 32'h27d4eb2d;
    localparam logic [31:0] MIX_MUL1   = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL2   = 32'h846ca68b;

    localparam logic [31:0] SEED_RESET      = 32'd1234;
    localparam logic [12:0] IN_FEAT_RESET   = 13'd512;
    localparam logic signed [7:0] W_MIN     = -8'sd127;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SEED    = 2'd0;
    localparam logic [1:0] CFG_LAYER   = 2'd1;
    localparam logic [1:0] CFG_TENSOR  = 2'd2;
    localparam logic [1:0] CFG_IN_FEAT = 2'd3;

    typedef struct packed {
        logic [31:0] seed_value;
        logic [5:0]  layer_number;
        logic [3:0]  tensor_id;
        logic [12:0] in_features;
    } cfg_t;

    // One queued activation; width is already limited to the lane count.
    typedef struct packed {
        logic signed [7:0] act_value;
        logic [11:0]       feature_index;
        logic [11:0]       tile_base;
        logic [3:0]        tile_width;
        logic              first_item;
        logic              last_item;
    } item_t;

endpackage

// ----- rtl/hwmac_front.sv -----
// Front end of the MAC tile: accepts input words, limits the lane count and
// holds them in a two-entry queue for the back end. Depends on hwmac_pkg.
module hwmac_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 q_valid,
    input  logic                 q_ready,
    output hwmac_pkg::item_t     q_item
);

    hwmac_pkg::item_t             entry_reg [hwmac_pkg::QUEUE_DEPTH];
    logic [hwmac_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [hwmac_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [hwmac_pkg::QCNT_W-1:0] count_reg;
    hwmac_pkg::item_t             in_item;
    logic [3:0]                   raw_width;
    logic                         push;
    logic                         pop;

    assign raw_width = s_tdata[35:32];

    always_comb
    begin
        in_item.act_value     = s_tdata[7:0];
        in_item.feature_index = s_tdata[19:8];
        in_item.tile_base     = s_tdata[31:20];
        in_item.tile_width    = (5'(raw_width) > 5'(hwmac_pkg::TILE_LANES))
                                ? 4'(hwmac_pkg::TILE_LANES) : raw_width;
        in_item.first_item    = s_tuser;
        in_item.last_item     = s_tlast;
    end

    assign s_tready = (count_reg != hwmac_pkg::QCNT_W'(hwmac_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/hwmac_back.sv -----
// Back end of the MAC tile: a sequencer that walks the active lanes of one
// item through a shared hash and multiply unit, keeps the lane accumulators
// and holds the result word for the receiver. Depends on hwmac_pkg.
module hwmac_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hwmac_pkg::cfg_t      cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  hwmac_pkg::item_t     q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [255:0]         m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_IDX,
        S_KEY,
        S_MIX1,
        S_MIX2,
        S_ACC,
        S_EMIT
    } state_t;

    state_t                       state_reg;
    hwmac_pkg::item_t             item_reg;
    logic [hwmac_pkg::LANE_W-1:0] lane_reg;
    logic [31:0]                  key_base_reg;
    logic [31:0]                  idx_reg;
    logic [31:0]                  hash_reg;
    logic [31:0]                  acc_reg [hwmac_pkg::TILE_LANES];
    logic                         out_valid_reg;
    logic [255:0]                 out_data_reg;

    logic [12:0]                  row;
    logic [25:0]                  row_offset;
    logic [31:0]                  key_base;
    logic [31:0]                  key_index;
    logic [31:0]                  mix1_in;
    logic [31:0]                  mix2_in;
    logic [31:0]                  mix_out;
    logic [7:0]                   top_byte;
    logic signed [7:0]            weight;
    logic signed [15:0]           product;
    logic [31:0]                  acc_sum;
    logic [4:0]                   lane_inc;
    logic [255:0]                 emit_data;

    always_comb
    begin
        row        = 13'(item_reg.tile_base) + 13'(lane_reg);
        row_offset = 26'(row) * 26'(cfg.in_features);
        key_base   = cfg.seed_value ^ hwmac_pkg::KEY_GOLDEN
                     ^ 32'((32'(cfg.layer_number) + 32'd1) * hwmac_pkg::KEY_LAYER)
                     ^ 32'((32'(cfg.tensor_id) + 32'd1) * hwmac_pkg::KEY_TENSOR);
        key_index  = 32'(idx_reg * hwmac_pkg::KEY_INDEX);
        mix1_in    = hash_reg ^ (hash_reg >> 16);
        mix2_in    = hash_reg ^ (hash_reg >> 15);
        mix_out    = hash_reg ^ (hash_reg >> 16);
        top_byte   = mix_out[31:24];
        // Top byte minus 128 is the byte with its sign bit flipped; the one
        // value below -127 is pulled up to -127.
        weight     = (top_byte == 8'd0) ? hwmac_pkg::W_MIN
                     : $signed({~top_byte[7], top_byte[6:0]});
        product    = 16'(weight) * 16'(item_reg.act_value);
        acc_sum    = acc_reg[lane_reg] + 32'(product);
        lane_inc   = 5'(lane_reg) + 5'd1;
    end

    always_comb
    begin
        emit_data = '0;
        for (int j = 0; j < hwmac_pkg::OUT_LANES; j++)
        begin
            if (j < hwmac_pkg::TILE_LANES && 5'(j) < 5'(item_reg.tile_width))
            begin
                emit_data[j*32 +: 32] = acc_reg[j];
            end
        end
    end

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            lane_reg      <= '0;
            key_base_reg  <= '0;
            idx_reg       <= '0;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int j = 0; j < hwmac_pkg::TILE_LANES; j++)
            begin
                acc_reg[j] <= '0;
            end
        end
        else
        begin
            // In the emit state the output register is handled below.
            if (out_valid_reg && m_tready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg  <= q_item;
                        state_reg <= S_BASE;
                    end
                end
                S_BASE:
                begin
                    key_base_reg <= key_base;
                    lane_reg     <= '0;
                    if (item_reg.first_item)
                    begin
                        for (int j = 0; j < hwmac_pkg::TILE_LANES; j++)
                        begin
                            acc_reg[j] <= '0;
                        end
                    end
                    if (item_reg.tile_width != 4'd0)
                    begin
                        state_reg <= S_IDX;
                    end
                    else if (item_reg.last_item)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDX:
                begin
                    idx_reg   <= 32'(row_offset) + 32'(item_reg.feature_index);
                    state_reg <= S_KEY;
                end
                S_KEY:
                begin
                    hash_reg  <= key_base_reg ^ key_index;
                    state_reg <= S_MIX1;
                end
                S_MIX1:
                begin
                    hash_reg  <= 32'(mix1_in * hwmac_pkg::MIX_MUL1);
                    state_reg <= S_MIX2;
                end
                S_MIX2:
                begin
                    hash_reg  <= 32'(mix2_in * hwmac_pkg::MIX_MUL2);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg[lane_reg] <= acc_sum;
                    if (lane_inc < 5'(item_reg.tile_width))
                    begin
                        lane_reg  <= lane_inc[hwmac_pkg::LANE_W-1:0];
                        state_reg <= S_IDX;
                    end
                    else if (item_reg.last_item)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= emit_data;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/hashed_weight_int8_mac_tile_top.sv -----
// Top level of the hashed-weight int8 MAC tile: configuration registers and
// the front and back ends. Depends on hwmac_pkg, hwmac_front and hwmac_back.
//
// Use of the block:
// The slave stream (s_tvalid/s_tready/s_tdata/s_tuser/s_tlast) carries one int8
// activation per word with its feature index, tile base and lane count; tuser
// marks the first word of a dot product (accumulators are cleared first) and
// tlast the last one (sums of lanes below its lane count are sent after its add,
// the rest as zero). The master stream (m_tvalid/m_tready/m_tdata) carries one
// word of eight 32-bit sums. The weights are not stored: each one is regenerated
// from a hash of the seed, layer, tensor and weight index. The configuration
// channel writes those registers and must only be used while the tile is idle.
// Sequence: the back end takes one word at a time and runs each active lane
// through one shared hash and multiply unit in five steps (index, key, two mix
// steps, accumulate); a last word then adds an emit step. A two-word queue sits
// in front, so input keeps flowing while the back end works, until the queue is
// full. Reset clears the queue, the accumulators and the output register and
// loads the register defaults (seed 1234, in_features 512). If the receiver
// stalls, the result is held in the output register; the next item still runs,
// and only a second result waits until the first is taken.
module hashed_weight_int8_mac_tile_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // act_value[7:0], feature_index[19:8],
                                    // tile_base[31:20], tile_width[35:32], zero fill
    input  logic         s_tuser,   // first_item
    input  logic         s_tlast,   // last_item
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,   // sum_lane0[31:0] up to sum_lane7[255:224]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    hwmac_pkg::cfg_t  cfg_reg;
    logic             q_valid;
    logic             q_ready;
    hwmac_pkg::item_t q_item;

    // Writes are always taken at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed_value   <= hwmac_pkg::SEED_RESET;
            cfg_reg.layer_number <= '0;
            cfg_reg.tensor_id    <= '0;
            cfg_reg.in_features  <= hwmac_pkg::IN_FEAT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hwmac_pkg::CFG_SEED:    cfg_reg.seed_value   <= cfg_data;
                hwmac_pkg::CFG_LAYER:   cfg_reg.layer_number <= cfg_data[5:0];
                hwmac_pkg::CFG_TENSOR:  cfg_reg.tensor_id    <= cfg_data[3:0];
                hwmac_pkg::CFG_IN_FEAT: cfg_reg.in_features  <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    hwmac_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    hwmac_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
